FILE: rtl/core/ntof_pkg.sv
// shared types, codes and constants of the neutron tof event transform
package ntof_pkg;

  // table depth and index width
  localparam int PIXELS = 16384;
  localparam int PIX_AW = $clog2(PIXELS);

  // request queue between front and back
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  // operation codes of an input request
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_WR_T0 = 2'd1;
  localparam logic [1:0] OP_WR_T1 = 2'd2;

  // transform modes
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_DYNAMIC = 2'd1;
  localparam logic [1:0] MODE_ENERGY  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PIXEL   = 3'd1;
  localparam logic [2:0] ST_ENTRY   = 3'd2;
  localparam logic [2:0] ST_TOFZERO = 3'd3;
  localparam logic [2:0] ST_DIVSAT  = 3'd4;

  // register indexes on the config port
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_L1    = 3'd1;
  localparam logic [2:0] REG_TICK  = 3'd2;
  localparam logic [2:0] REG_SIZE0 = 3'd3;
  localparam logic [2:0] REG_SIZE1 = 3'd4;

  // queue entry kinds
  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_STATIC = 2'd1;
  localparam logic [1:0] KIND_ENERGY = 2'd2;

  // 0.5*Mn/e scaled to meV*ns^2/m^2
  localparam logic [42:0] NEUTRON_K  = 43'd5227120520000;
  localparam logic [63:0] RESULT_MAX = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [13:0] pixel_id;
    logic [31:0] tof;
    logic [31:0] table_value;
  } in_t;

  typedef struct packed {
    logic signed [47:0] result_value;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] l1;
    logic [19:0] tick;
    logic [14:0] size0;
    logic [14:0] size1;
  } cfg_t;

  // word holds the static product or the tof in ns
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [63:0] word;
    logic [31:0] ef;
    logic [31:0] l2;
  } q_entry_t;

endpackage

FILE: rtl/core/ntof_front.sv
// front end: table memories, event lookup and classification
module ntof_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ntof_pkg::in_t     item,
  input  ntof_pkg::cfg_t    cfg,
  output logic              a_valid,
  output logic              push,
  output ntof_pkg::q_entry_t entry
);
  import ntof_pkg::*;

  logic [31:0]       t0_mem [PIXELS];
  logic [31:0]       t1_mem [PIXELS];
  logic              a_v_r;
  logic [13:0]       a_px_r;
  logic [31:0]       a_tof_r;
  logic [31:0]       t0_q_r;
  logic [31:0]       t1_q_r;
  logic [63:0]       prod;
  logic [51:0]       tns;
  logic              out0;
  logic              out1;

  // table writes and event lookups
  always_ff @(posedge clk) begin
    if (accept && item.operation == OP_WR_T0) begin
      t0_mem[item.pixel_id[PIX_AW-1:0]] <= item.table_value;
    end
    if (accept && item.operation == OP_WR_T1) begin
      t1_mem[item.pixel_id[PIX_AW-1:0]] <= item.table_value;
    end
    if (accept && item.operation == OP_EVENT) begin
      t0_q_r  <= t0_mem[item.pixel_id[PIX_AW-1:0]];
      t1_q_r  <= t1_mem[item.pixel_id[PIX_AW-1:0]];
      a_px_r  <= item.pixel_id;
      a_tof_r <= item.tof;
    end
  end

  // lookup stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept && item.operation == OP_EVENT;
    end
  end

  assign prod = {32'd0, a_tof_r} * {32'd0, t0_q_r};
  assign tns  = {20'd0, a_tof_r} * {32'd0, cfg.tick};
  assign out0 = {1'b0, a_px_r} >= cfg.size0;
  assign out1 = {1'b0, a_px_r} >= cfg.size1;

  // classify in the order pixel, entry, tof
  always_comb begin
    entry.kind   = KIND_DONE;
    entry.status = ST_OK;
    entry.word   = '0;
    entry.ef     = t0_q_r;
    entry.l2     = t1_q_r;
    unique case (cfg.mode)
      MODE_STATIC: begin
        if (out0) begin
          entry.status = ST_PIXEL;
        end else if (t0_q_r == '0) begin
          entry.status = ST_ENTRY;
        end else if (a_tof_r == '0) begin
          entry.status = ST_TOFZERO;
        end else begin
          entry.kind = KIND_STATIC;
          entry.word = prod;
        end
      end
      MODE_ENERGY: begin
        if (out0 || out1) begin
          entry.status = ST_PIXEL;
        end else if (t0_q_r == '0 || t1_q_r == '0) begin
          entry.status = ST_ENTRY;
        end else if (a_tof_r == '0 || cfg.tick == '0) begin
          entry.status = ST_TOFZERO;
        end else begin
          entry.kind = KIND_ENERGY;
          entry.word = {12'd0, tns};
        end
      end
      default: begin
        entry.status = ST_OK;
      end
    endcase
  end

  assign push    = a_v_r;
  assign a_valid = a_v_r;

endmodule

FILE: rtl/core/ntof_fifo.sv
// short request queue between front and back
module ntof_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ntof_pkg::q_entry_t din,
  input  logic               pop,
  output ntof_pkg::q_entry_t dout,
  output logic               empty,
  output logic [ntof_pkg::QAW:0] count
);
  import ntof_pkg::*;

  localparam logic [QAW:0] FULL_C = QDEPTH[QAW:0];

  q_entry_t       q_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
  end

  assign dout  = q_r[rp_r];
  assign empty = cnt_r == '0;
  assign count = cnt_r;

  // no overflow
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == FULL_C) |-> (!push || pop))
    else $error("request queue overflow");

endmodule

FILE: rtl/core/ntof_energy.sv
// energy transfer unit: shared one-bit-per-cycle multiply, divide and square root
module ntof_energy (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ntof_pkg::q_entry_t job,
  input  logic [31:0]        l1,
  output logic               ready,
  output logic               done,
  output ntof_pkg::out_t     result
);
  import ntof_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_L2SQ = 4'd1;
  localparam logic [3:0] S_KMUL = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DIST = 4'd5;
  localparam logic [3:0] S_DSQ  = 4'd6;
  localparam logic [3:0] S_L1SQ = 4'd7;
  localparam logic [3:0] S_L1K  = 4'd8;
  localparam logic [3:0] S_DIV2 = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]   st_r,  st_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [127:0] ma_r,  ma_nxt;
  logic [63:0]  mb_r,  mb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [127:0] num_r, num_nxt;
  logic [127:0] rem_r, rem_nxt;
  logic [127:0] quo_r, quo_nxt;
  logic [127:0] den_r, den_nxt;
  logic [31:0]  ef_r,  ef_nxt;
  logic [67:0]  tq_r,  tq_nxt;
  logic         dz_r,  dz_nxt;

  logic [127:0] mul_sum;
  logic [127:0] rsh;
  logic         dge;
  logic [127:0] ssh;
  logic [127:0] strial;
  logic         sge;
  logic [67:0]  t2;
  logic [67:0]  dval;
  logic [63:0]  lim;
  logic [63:0]  diff;

  // datapath terms shared by the steps
  assign mul_sum = acc_r + (mb_r[0] ? ma_r : '0);
  assign rsh     = {rem_r[126:0], num_r[127]};
  assign dge     = rsh >= den_r;
  assign ssh     = {rem_r[125:0], num_r[127:126]};
  assign strial  = {quo_r[125:0], 2'b01};
  assign sge     = ssh >= strial;
  assign t2      = {4'd0, quo_r[63:0]};
  assign dval    = (tq_r >= t2) ? (tq_r - t2) : (t2 - tq_r);
  assign lim     = RESULT_MAX + {32'd0, ef_r};
  assign diff    = quo_r[63:0] - {32'd0, ef_r};

  // sequencer
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    acc_nxt = acc_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    ef_nxt  = ef_r;
    tq_nxt  = tq_r;
    dz_nxt  = dz_r;
    unique case (st_r) inside
      S_IDLE: begin
        if (start) begin
          ef_nxt  = job.ef;
          tq_nxt  = {job.word[51:0], 16'd0};
          ma_nxt  = {96'd0, job.l2};
          mb_nxt  = {32'd0, job.l2};
          acc_nxt = '0;
          cnt_nxt = '0;
          dz_nxt  = 1'b0;
          st_nxt  = S_L2SQ;
        end
      end
      S_L2SQ, S_KMUL, S_DSQ, S_L1SQ, S_L1K: begin
        acc_nxt = mul_sum;
        ma_nxt  = {ma_r[126:0], 1'b0};
        mb_nxt  = {1'b0, mb_r[63:1]};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          unique case (st_r) inside
            S_L2SQ, S_L1SQ: begin
              ma_nxt = {85'd0, NEUTRON_K};
              mb_nxt = mul_sum[63:0];
              st_nxt = (st_r == S_L2SQ) ? S_KMUL : S_L1K;
            end
            S_KMUL: begin
              num_nxt = {mul_sum[111:0], 16'd0};
              den_nxt = {96'd0, ef_r};
              rem_nxt = '0;
              quo_nxt = '0;
              st_nxt  = S_DIV1;
            end
            S_DSQ: begin
              den_nxt = mul_sum;
              ma_nxt  = {96'd0, l1};
              mb_nxt  = {32'd0, l1};
              st_nxt  = S_L1SQ;
            end
            default: begin
              num_nxt = {mul_sum[111:0], 16'd0} + {1'b0, den_r[127:1]};
              rem_nxt = '0;
              quo_nxt = '0;
              st_nxt  = S_DIV2;
            end
          endcase
        end
      end
      S_DIV1, S_DIV2: begin
        rem_nxt = dge ? (rsh - den_r) : rsh;
        quo_nxt = {quo_r[126:0], dge};
        num_nxt = {num_r[126:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          cnt_nxt = '0;
          if (st_r == S_DIV1) begin
            num_nxt = {quo_r[126:0], dge};
            rem_nxt = '0;
            quo_nxt = '0;
            st_nxt  = S_SQRT;
          end else begin
            st_nxt = S_FIN;
          end
        end
      end
      S_SQRT: begin
        rem_nxt = sge ? (ssh - strial) : ssh;
        quo_nxt = {quo_r[126:0], sge};
        num_nxt = {num_r[125:0], 2'b00};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt = '0;
          st_nxt  = S_DIST;
        end
      end
      S_DIST: begin
        if (dval == '0) begin
          dz_nxt = 1'b1;
          st_nxt = S_FIN;
        end else if (|dval[67:62]) begin
          quo_nxt = '0;
          st_nxt  = S_FIN;
        end else begin
          ma_nxt  = {60'd0, dval};
          mb_nxt  = dval[63:0];
          acc_nxt = '0;
          st_nxt  = S_DSQ;
        end
      end
      S_FIN: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    ef_r  <= ef_nxt;
    tq_r  <= tq_nxt;
    dz_r  <= dz_nxt;
  end

  // final subtract and saturation
  always_comb begin
    if (dz_r) begin
      result.result_value = '0;
      result.status       = ST_DIVSAT;
    end else if ((|quo_r[127:64]) || (quo_r[63:0] > lim)) begin
      result.result_value = RESULT_MAX[47:0];
      result.status       = ST_DIVSAT;
    end else begin
      result.result_value = diff[47:0];
      result.status       = ST_OK;
    end
  end

  assign ready = st_r == S_IDLE;
  assign done  = st_r == S_FIN;

endmodule

FILE: rtl/core/ntof_back.sv
// back end: drains the queue, finishes static results, runs the energy unit
module ntof_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  ntof_pkg::q_entry_t head,
  input  logic [31:0]        l1,
  output logic               pop,
  output logic               out_valid,
  output ntof_pkg::out_t     out_item
);
  import ntof_pkg::*;

  logic   e_ready;
  logic   e_done;
  logic   e_start;
  out_t   e_res;
  out_t   res_nxt;
  logic   out_v_r;
  out_t   out_r;

  assign pop     = !empty && e_ready;
  assign e_start = pop && head.kind == KIND_ENERGY;

  ntof_energy u_energy (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (e_start),
    .job    (head),
    .l1     (l1),
    .ready  (e_ready),
    .done   (e_done),
    .result (e_res)
  );

  // result selection
  always_comb begin
    if (e_done) begin
      res_nxt = e_res;
    end else if (head.kind == KIND_STATIC && head.word > RESULT_MAX) begin
      res_nxt.result_value = RESULT_MAX[47:0];
      res_nxt.status       = ST_DIVSAT;
    end else if (head.kind == KIND_STATIC) begin
      res_nxt.result_value = head.word[47:0];
      res_nxt.status       = ST_OK;
    end else begin
      res_nxt.result_value = '0;
      res_nxt.status       = head.status;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= e_done || (pop && head.kind != KIND_ENERGY);
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // energy unit only started when free
  a_start_ready: assert property (@(posedge clk) disable iff (!rst_n)
    e_start |-> e_ready)
    else $error("energy unit started while busy");

  // every result comes from a pop or a finished energy request
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $past(e_done || pop))
    else $error("result without a source");

  // a nonzero divide or saturation result is the clamp value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status == ST_DIVSAT && out_r.result_value != '0)
      |-> out_r.result_value == RESULT_MAX[47:0])
    else $error("bad saturation value");

endmodule

FILE: rtl/core/neutron_tof_event_transform.sv
// top level: config registers, front end, request queue and back end
// static, dynamic and rejected events pass the lookup stage, the queue and the result register
// energy events run l2 squared, K multiply, divide, square root, distance, distance squared,
// l1 squared, l1 multiply and divide (the last four skipped at a zero or >= 2^62 distance)
// throughput: one request per cycle while not busy; an energy event holds the back end
// reset: synchronous active-low; clears control and config, tables are undefined until written
module neutron_tof_event_transform (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ntof_pkg::in_t  in_item,
  output logic           out_valid,
  output ntof_pkg::out_t out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ntof_pkg::*;

  localparam logic [QAW+1:0] BUSY_LIM = QDEPTH[QAW+1:0];

  cfg_t         cfg_r;
  logic         accept;
  logic         a_valid;
  logic         push;
  q_entry_t     entry;
  q_entry_t     head;
  logic         pop;
  logic         empty;
  logic [QAW:0] count;
  logic         wr_en;

  // config register writes
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_STATIC;
      cfg_r.l1    <= '0;
      cfg_r.tick  <= 20'd100;
      cfg_r.size0 <= '0;
      cfg_r.size1 <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_MODE:  cfg_r.mode  <= pwdata[1:0];
        REG_L1:    cfg_r.l1    <= pwdata;
        REG_TICK:  cfg_r.tick  <= pwdata[19:0];
        REG_SIZE0: cfg_r.size0 <= pwdata[14:0];
        REG_SIZE1: cfg_r.size1 <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // config register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:  prdata = {30'd0, cfg_r.mode};
      REG_L1:    prdata = cfg_r.l1;
      REG_TICK:  prdata = {12'd0, cfg_r.tick};
      REG_SIZE0: prdata = {17'd0, cfg_r.size0};
      REG_SIZE1: prdata = {17'd0, cfg_r.size1};
      default:   prdata = '0;
    endcase
  end

  // hold off requests while the queue could fill
  assign busy   = ({1'b0, count} + {{(QAW+1){1'b0}}, a_valid}) >= BUSY_LIM;
  assign accept = start && !busy;

  ntof_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .cfg     (cfg_r),
    .a_valid (a_valid),
    .push    (push),
    .entry   (entry)
  );

  ntof_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .empty (empty),
    .count (count)
  );

  ntof_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .l1        (cfg_r.l1),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
